// ===== design/fqs_pkg.sv =====
// Shared types and codes for the searchable FIFO queue.
`timescale 1ns / 1ps

package fqs_pkg;

  // Operation codes carried on the opcode input.
  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_DEQUEUE = 2'd1,
    OP_SEARCH  = 2'd2,
    OP_DISPLAY = 2'd3
  } op_t;

  // Status codes carried on each result.
  typedef enum logic [2:0] {
    STAT_DONE      = 3'd0,
    STAT_FULL      = 3'd1,
    STAT_EMPTY     = 3'd2,
    STAT_MATCH     = 3'd3,
    STAT_NOT_FOUND = 3'd4,
    STAT_LISTED    = 3'd5
  } status_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEQ,
    ST_CHECK,
    ST_SEND,
    ST_FLUSH,
    ST_FINAL
  } state_t;

  // Result field widths and the per-operation result cap.
  localparam int POS_W   = 4;
  localparam int VALUE_W = 32;
  localparam int OCC_W   = 5;
  localparam int NRES_W  = 5;
  localparam logic [NRES_W-1:0] RESULT_CAP = 5'd16;

  // One result, less the occupancy, which is taken from the count.
  typedef struct packed {
    status_t            status;
    logic [POS_W-1:0]   position;
    logic [VALUE_W-1:0] value;
    logic               last;
  } result_t;

endpackage

// ===== design/fqs_store.sv =====
// Entry memory of the queue: one write port, one registered read port.
`timescale 1ns / 1ps

module fqs_store #(
  parameter int DEPTH = 16,
  parameter int IDX_W = 4
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [IDX_W-1:0]           waddr,
  input  logic [fqs_pkg::VALUE_W-1:0] wdata,
  input  logic [IDX_W-1:0]           raddr,
  output logic [fqs_pkg::VALUE_W-1:0] rdata
);
  import fqs_pkg::*;

  logic [VALUE_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, read every cycle, data registered.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== design/fifo_queue_with_search.sv =====
// Top level of the searchable FIFO queue: sequencer, pointers and result register.
// Enqueue and a full or empty report give their result in the cycle after the input
// transfer; a dequeue first passes ST_DEQ, which captures the registered head read. Search
// and display check one entry a cycle with one read port and one comparator, except while
// a held result waits for output in ST_SEND. Input is ready again the cycle after the final
// result transfer. Synchronous reset empties the queue and leaves stored entries.
`timescale 1ns / 1ps

module fifo_queue_with_search #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  opcode,
  input  logic signed [31:0]          in_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [2:0]                  status,
  output logic [fqs_pkg::POS_W-1:0]   position,
  output logic signed [31:0]          out_value,
  output logic [fqs_pkg::OCC_W-1:0]   occupancy,
  output logic                        last
);
  import fqs_pkg::*;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_SLOT  = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);

  // Control registers.
  state_t             state, state_next;
  logic [IDX_W-1:0]   head, head_next;
  logic [IDX_W-1:0]   tail, tail_next;
  logic [CNT_W-1:0]   count, count_next;
  logic [IDX_W-1:0]   slot;
  logic [CNT_W-1:0]   idx;
  logic [NRES_W-1:0]  nres;
  logic               pend_valid;

  // Payload registers.
  op_t                op_q;
  logic [VALUE_W-1:0] value_q;
  logic [POS_W-1:0]   pend_pos;
  logic [VALUE_W-1:0] pend_value;
  result_t            out_q;
  logic [OCC_W-1:0]   occ_q;

  // Datapath controls.
  logic               in_fire, out_fire;
  logic               mem_we;
  logic [IDX_W-1:0]   rd_addr;
  logic [VALUE_W-1:0] rd_data;
  logic [IDX_W-1:0]   head_inc, tail_inc, slot_inc;
  logic               hit, at_end, cap_end, scan_end;
  logic               scan_start, scan_step, nres_inc;
  logic               pend_load, pend_clear;
  logic               out_load;
  result_t            out_next;
  logic [POS_W-1:0]   idx_pos, count_pos;
  logic [31:0]        idx_wide, count_wide, count_next_wide;

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_SEND) || (state == ST_FLUSH) || (state == ST_FINAL);
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;

  // Ring pointer increments.
  assign head_inc = (head == LAST_SLOT) ? '0 : head + IDX_W'(1);
  assign tail_inc = (tail == LAST_SLOT) ? '0 : tail + IDX_W'(1);
  assign slot_inc = (slot == LAST_SLOT) ? '0 : slot + IDX_W'(1);

  // Read the head when idle, the following entry while checking, else the scan slot.
  always_comb begin
    case (state)
      ST_IDLE:  rd_addr = head;
      ST_CHECK: rd_addr = slot_inc;
      default:  rd_addr = slot;
    endcase
  end

  fqs_store #(
    .DEPTH (QUEUE_DEPTH),
    .IDX_W (IDX_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (tail),
    .wdata (in_value),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Shared compare and scan end tests.
  assign hit      = (op_q == OP_DISPLAY) || (rd_data == value_q);
  assign at_end   = ((idx + CNT_W'(1)) == count);
  assign cap_end  = (nres == RESULT_CAP - NRES_W'(1));
  assign scan_end = at_end || (hit && cap_end);

  // Positions and occupancy are masked to their field widths.
  assign idx_wide        = 32'(idx);
  assign count_wide      = 32'(count);
  assign count_next_wide = 32'(count_next);
  assign idx_pos         = idx_wide[POS_W-1:0];
  assign count_pos       = count_wide[POS_W-1:0];

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          if (op_t'(opcode) == OP_ENQUEUE || count == '0) begin
            state_next = ST_FINAL;
          end else if (op_t'(opcode) == OP_DEQUEUE) begin
            state_next = ST_DEQ;
          end else begin
            state_next = ST_CHECK;
          end
        end
      end
      ST_DEQ: state_next = ST_FINAL;
      ST_CHECK: begin
        if (hit && pend_valid) begin
          state_next = scan_end ? ST_FLUSH : ST_SEND;
        end else if (scan_end) begin
          state_next = ST_FINAL;
        end
      end
      ST_SEND: begin
        if (out_fire) state_next = ST_CHECK;
      end
      ST_FLUSH: begin
        if (out_fire) state_next = ST_FINAL;
      end
      ST_FINAL: begin
        if (out_fire) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath controls and the next result.
  always_comb begin
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    mem_we     = 1'b0;
    scan_start = 1'b0;
    scan_step  = 1'b0;
    nres_inc   = 1'b0;
    pend_load  = 1'b0;
    pend_clear = 1'b0;
    out_load   = 1'b0;
    out_next   = '{status: STAT_DONE, position: '0, value: '0, last: 1'b1};
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          scan_start = 1'b1;
          if (op_t'(opcode) == OP_ENQUEUE) begin
            out_load = 1'b1;
            if (count == FULL_COUNT) begin
              out_next.status = STAT_FULL;
            end else begin
              mem_we            = 1'b1;
              tail_next         = tail_inc;
              count_next        = count + CNT_W'(1);
              out_next.position = count_pos;
            end
          end else if (count == '0) begin
            out_load        = 1'b1;
            out_next.status = STAT_EMPTY;
          end else if (op_t'(opcode) == OP_DEQUEUE) begin
            head_next  = head_inc;
            count_next = count - CNT_W'(1);
          end
        end
      end
      ST_DEQ: begin
        out_load       = 1'b1;
        out_next.value = rd_data;
      end
      ST_CHECK: begin
        scan_step = !scan_end;
        if (hit) begin
          nres_inc = 1'b1;
          if (pend_valid) begin
            // Send the held hit now that a later one exists.
            out_load          = 1'b1;
            out_next.status   = (op_q == OP_DISPLAY) ? STAT_LISTED : STAT_MATCH;
            out_next.position = pend_pos;
            out_next.value    = pend_value;
            out_next.last     = 1'b0;
            pend_load         = 1'b1;
          end else if (scan_end) begin
            out_load          = 1'b1;
            out_next.status   = (op_q == OP_DISPLAY) ? STAT_LISTED : STAT_MATCH;
            out_next.position = idx_pos;
            out_next.value    = rd_data;
          end else begin
            pend_load = 1'b1;
          end
        end else if (scan_end) begin
          out_load   = 1'b1;
          pend_clear = 1'b1;
          if (pend_valid) begin
            out_next.status   = (op_q == OP_DISPLAY) ? STAT_LISTED : STAT_MATCH;
            out_next.position = pend_pos;
            out_next.value    = pend_value;
          end else begin
            out_next.status = STAT_NOT_FOUND;
          end
        end
      end
      ST_FLUSH: begin
        if (out_fire) begin
          out_load          = 1'b1;
          pend_clear        = 1'b1;
          out_next.status   = (op_q == OP_DISPLAY) ? STAT_LISTED : STAT_MATCH;
          out_next.position = pend_pos;
          out_next.value    = pend_value;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      head       <= '0;
      tail       <= '0;
      count      <= '0;
      slot       <= '0;
      idx        <= '0;
      nres       <= '0;
      pend_valid <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
      if (scan_start) begin
        slot       <= head;
        idx        <= '0;
        nres       <= '0;
        pend_valid <= 1'b0;
      end else begin
        if (scan_step) begin
          slot <= slot_inc;
          idx  <= idx + CNT_W'(1);
        end
        if (nres_inc) nres <= nres + NRES_W'(1);
        if (pend_load) begin
          pend_valid <= 1'b1;
        end else if (pend_clear) begin
          pend_valid <= 1'b0;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_q    <= op_t'(opcode);
      value_q <= in_value;
    end
    if (pend_load) begin
      pend_pos   <= idx_pos;
      pend_value <= rd_data;
    end
    if (out_load) begin
      out_q <= out_next;
      occ_q <= count_next_wide[OCC_W-1:0];
    end
  end

  assign status    = out_q.status;
  assign position  = out_q.position;
  assign out_value = out_q.value;
  assign occupancy = occ_q;
  assign last      = out_q.last;

endmodule
